@@ src/ptbt_pkg.sv @@
// ----------------------------------------------------------------------------
// ptbt_pkg
// Shared types and constants of the pan/tilt blob tracker: status codes,
// register indexes, register widths and reset values, tracking divisor.
// ----------------------------------------------------------------------------
package ptbt_pkg;

    typedef logic [2:0] t_status;
    typedef logic [2:0] t_cfg_idx;

    localparam t_status ST_TRACK  = 3'd0;
    localparam t_status ST_ABSENT = 3'd1;
    localparam t_status ST_MISS   = 3'd2;
    localparam t_status ST_LOST   = 3'd3;
    localparam t_status ST_SWEEP  = 3'd4;

    localparam t_cfg_idx CFG_TOLERANCE  = 3'd0;
    localparam t_cfg_idx CFG_MISS_LIMIT = 3'd1;
    localparam t_cfg_idx CFG_SWEEP_STEP = 3'd2;
    localparam t_cfg_idx CFG_TRACK_MAX  = 3'd3;
    localparam t_cfg_idx CFG_TILT_HIGH  = 3'd4;
    localparam t_cfg_idx CFG_TILT_LOW   = 3'd5;

    localparam int CFG_DW   = 21;
    localparam int TOL_W    = 9;
    localparam int STEP_W   = 16;
    localparam int LEVEL_W  = 21;
    localparam int MISS_W   = 17;

    localparam logic [TOL_W-1:0]   TOL_RST        = 9'd5;
    localparam logic [STEP_W-1:0]  MISS_LIMIT_RST = 16'd200;
    localparam logic [STEP_W-1:0]  SWEEP_STEP_RST = 16'd5243;
    localparam logic [STEP_W-1:0]  TRACK_MAX_RST  = 16'd5243;
    localparam logic [LEVEL_W-1:0] TILT_HIGH_RST  = 21'd629146;
    localparam logic [LEVEL_W-1:0] TILT_LOW_RST   = 21'd419430;

    // offset magnitude above which the configured maximum step is used
    localparam int TRACK_KNEE = 450;

    // 150000 = 2^4 * 9375; the odd part is divided by reciprocal multiply
    localparam int TRACK_DIV_POW2    = 4;
    localparam int TRACK_DIV_ODD     = 9375;
    localparam int TRACK_RECIP_SHIFT = 23;

endpackage

@@ src/pan_tilt_blob_tracker_top.sv @@
// ----------------------------------------------------------------------------
// pan_tilt_blob_tracker_top
// Per-frame pan/tilt steering from a decoded blob coordinate pair.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one blob_x/blob_y word per frame.
//   Output channel (o_valid / i_stall) returns one result word per input word:
//   pan and tilt positions (unsigned Q1.POS_FRAC_BITS), servo write strobes,
//   status and the sweep low-end flag.
//   Config channel (i_cfg_valid / o_cfg_ready) writes one register per word by
//   index; ready is always high. Write only while the block is idle.
//   Path: the accepting edge loads the input register, and o_valid rises when
//   the word moves on into the result register. Throughput: one word per cycle
//   while the receiver does not stall; the tracker state is updated in the
//   result stage, so each word sees the state left by the one before.
//   Receiver stall: the result register holds, the input register holds once
//   occupied, and o_stall rises; no word is dropped.
//   Reset: positions go to half travel, sweep direction forward, miss count 0,
//   registers to their defaults, both pipeline stages empty.
// ----------------------------------------------------------------------------
module pan_tilt_blob_tracker_top
    import ptbt_pkg::*;
#(
    parameter int POS_FRAC_BITS = 20,
    parameter int COORD_BITS    = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [COORD_BITS-1:0]    i_blob_x,
    input  logic [COORD_BITS-1:0]    i_blob_y,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [POS_FRAC_BITS:0]   o_pan_pos,
    output logic [POS_FRAC_BITS:0]   o_tilt_pos,
    output logic                     o_pan_write,
    output logic                     o_tilt_write,
    output t_status                  o_status,
    output logic                     o_sweep_lost_end,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  t_cfg_idx                 i_cfg_index,
    input  logic [CFG_DW-1:0]        i_cfg_data
);

    localparam int PW = POS_FRAC_BITS + 1;
    localparam int CB = COORD_BITS;
    localparam int AW = PW + 18;
    localparam int RW = POS_FRAC_BITS + 6;
    localparam int MW = CB + RW;
    localparam int RECIP_EXP = POS_FRAC_BITS - TRACK_DIV_POW2 + TRACK_RECIP_SHIFT;
    localparam longint unsigned RECIP_L =
        ((64'd1 << RECIP_EXP) + 64'(TRACK_DIV_ODD) - 64'd1) / 64'(TRACK_DIV_ODD);
    localparam logic [RW-1:0] RECIP  = RW'(RECIP_L);
    localparam logic [PW-1:0] FULL   = {1'b1, {POS_FRAC_BITS{1'b0}}};
    localparam logic [PW-1:0] HALF   = {2'b01, {(POS_FRAC_BITS-1){1'b0}}};
    localparam logic [CB-1:0] CENTRE = {1'b1, {(CB-1){1'b0}}};

    // configuration
    logic [TOL_W-1:0]   r_tol;
    logic [STEP_W-1:0]  r_miss_limit;
    logic [STEP_W-1:0]  r_sweep_step;
    logic [STEP_W-1:0]  r_track_max;
    logic [LEVEL_W-1:0] r_tilt_high;
    logic [LEVEL_W-1:0] r_tilt_low;

    // tracker state
    logic [PW-1:0]      r_pan, n_pan;
    logic [PW-1:0]      r_tilt, n_tilt;
    logic               r_fwd, n_fwd;
    logic [MISS_W-1:0]  r_miss, n_miss;

    // input stage
    logic               r_in_valid;
    logic [CB-1:0]      r_x, r_y;

    // result stage
    logic               r_out_valid;
    logic [PW-1:0]      r_o_pan, r_o_tilt;
    logic               r_o_pan_w, r_o_tilt_w, r_o_lost;
    t_status            r_o_status;
    logic               n_pan_w, n_tilt_w, n_lost;
    t_status            n_status;

    logic               adv;
    logic               in_acc;

    assign adv    = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !adv;
    assign in_acc = i_valid && !o_stall;

    function automatic logic [PW-1:0] f_clamp(input logic signed [AW-1:0] v);
        logic [PW-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed(AW'(FULL))) begin
            res = FULL;
        end else begin
            res = PW'(v);
        end
        return res;
    endfunction

    function automatic logic [CB-1:0] f_mag(input logic signed [CB:0] off);
        logic signed [CB:0] a;
        a = (off < 0) ? -off : off;
        return a[CB-1:0];
    endfunction

    // signed step: trunc(|off| * 2^F / 150000), or the max step past the knee
    function automatic logic signed [AW-1:0] f_step(input logic signed [CB:0] off,
                                                    input logic [STEP_W-1:0] max_step);
        logic [CB-1:0]          mag;
        logic [MW-1:0]          prod;
        logic signed [AW-1:0]   s;
        mag  = f_mag(off);
        prod = MW'(mag) * MW'(RECIP);
        if (16'(mag) > 16'(TRACK_KNEE)) begin
            s = $signed(AW'(max_step));
        end else begin
            s = $signed(AW'(prod >> TRACK_RECIP_SHIFT));
        end
        return (off < 0) ? -s : s;
    endfunction

    always_comb begin
        logic signed [CB:0] offx, offy;
        logic [PW-1:0]      sp;
        offx     = $signed({1'b0, CENTRE}) - $signed({1'b0, r_x});
        offy     = $signed({1'b0, CENTRE}) - $signed({1'b0, r_y});
        n_pan    = r_pan;
        n_tilt   = r_tilt;
        n_fwd    = r_fwd;
        n_miss   = r_miss;
        n_pan_w  = 1'b0;
        n_tilt_w = 1'b0;
        n_lost   = 1'b0;
        n_status = ST_TRACK;
        sp       = '0;
        if (r_x == '0 && r_y == '0) begin
            n_status = ST_ABSENT;
        end else if (r_x == '1 && r_y == '1) begin
            if (r_miss < {1'b0, r_miss_limit}) begin
                n_miss   = r_miss + 1'b1;
                n_status = ST_MISS;
            end else if (r_miss == {1'b0, r_miss_limit}) begin
                n_miss   = r_miss + 1'b1;
                n_status = ST_LOST;
            end else begin
                if (r_fwd) begin
                    n_tilt = f_clamp($signed(AW'(r_tilt_high)));
                    sp     = f_clamp($signed(AW'(r_pan)) + $signed(AW'(r_sweep_step)));
                end else begin
                    n_tilt = f_clamp($signed(AW'(r_tilt_low)));
                    sp     = f_clamp($signed(AW'(r_pan)) - $signed(AW'(r_sweep_step)));
                end
                n_pan = sp;
                if (sp == '0) begin
                    n_fwd  = 1'b1;
                    n_lost = 1'b1;
                end else if (sp == FULL) begin
                    n_fwd = 1'b0;
                end
                n_pan_w  = 1'b1;
                n_tilt_w = 1'b1;
                n_status = ST_SWEEP;
            end
        end else begin
            n_miss   = '0;
            n_pan    = f_clamp($signed(AW'(r_pan)) - f_step(offx, r_track_max));
            n_tilt   = f_clamp($signed(AW'(r_tilt)) + f_step(offy, r_track_max));
            n_pan_w  = 16'(f_mag(offx)) > 16'(r_tol);
            n_tilt_w = 16'(f_mag(offy)) > 16'(r_tol);
            n_status = ST_TRACK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol        <= TOL_RST;
            r_miss_limit <= MISS_LIMIT_RST;
            r_sweep_step <= SWEEP_STEP_RST;
            r_track_max  <= TRACK_MAX_RST;
            r_tilt_high  <= TILT_HIGH_RST;
            r_tilt_low   <= TILT_LOW_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TOLERANCE:  r_tol        <= i_cfg_data[TOL_W-1:0];
                CFG_MISS_LIMIT: r_miss_limit <= i_cfg_data[STEP_W-1:0];
                CFG_SWEEP_STEP: r_sweep_step <= i_cfg_data[STEP_W-1:0];
                CFG_TRACK_MAX:  r_track_max  <= i_cfg_data[STEP_W-1:0];
                CFG_TILT_HIGH:  r_tilt_high  <= i_cfg_data[LEVEL_W-1:0];
                CFG_TILT_LOW:   r_tilt_low   <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pan       <= HALF;
            r_tilt      <= HALF;
            r_fwd       <= 1'b1;
            r_miss      <= '0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (adv && r_in_valid) begin
                r_pan  <= n_pan;
                r_tilt <= n_tilt;
                r_fwd  <= n_fwd;
                r_miss <= n_miss;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x <= i_blob_x;
            r_y <= i_blob_y;
        end
        if (adv && r_in_valid) begin
            r_o_pan    <= n_pan;
            r_o_tilt   <= n_tilt;
            r_o_pan_w  <= n_pan_w;
            r_o_tilt_w <= n_tilt_w;
            r_o_status <= n_status;
            r_o_lost   <= n_lost;
        end
    end

    assign o_cfg_ready      = 1'b1;
    assign o_valid          = r_out_valid;
    assign o_pan_pos        = r_o_pan;
    assign o_tilt_pos       = r_o_tilt;
    assign o_pan_write      = r_o_pan_w;
    assign o_tilt_write     = r_o_tilt_w;
    assign o_status         = r_o_status;
    assign o_sweep_lost_end = r_o_lost;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pan_pos <= FULL) && (o_tilt_pos <= FULL))
        else $error("position beyond full travel");

    a_sweep_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_SWEEP) |-> o_pan_write && o_tilt_write)
        else $error("sweep word without both servo writes");

    a_lost_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sweep_lost_end |-> (o_status == ST_SWEEP) && (o_pan_pos == '0))
        else $error("low-end flag outside a sweep at pan zero");

    a_absent_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_ABSENT) |-> !o_pan_write && !o_tilt_write)
        else $error("servo write while sensor absent");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_x) && $stable(r_y))
        else $error("input stage lost a word under stall");

endmodule
